@@ src/tbl_pkg.sv @@
// ----------------------------------------------------------------------------
// Tape block loader package
// Types, status codes and register indexes shared by the channel interfaces
// and the loader.
// ----------------------------------------------------------------------------
package tbl_pkg;

    // Block outcome codes carried in status_code.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FLAG  = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;
    localparam logic [1:0] ST_SUM   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_FLAG   = 2'd0;
    localparam logic [1:0] REG_LENGTH = 2'd1;
    localparam logic [1:0] REG_START  = 2'd2;
    localparam logic [1:0] REG_VERIFY = 2'd3;

    // One tape byte with its end-of-block mark.
    typedef struct packed {
        logic [7:0] tape_byte;
        logic       block_end;
    } in_item_t;

    // One result: an optional memory write and an optional block status.
    typedef struct packed {
        logic        write_enable;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic        status_valid;
        logic [1:0]  status_code;
    } out_item_t;

endpackage

@@ src/tbl_if.sv @@
// ----------------------------------------------------------------------------
// Tape block loader channels
// Valid/ready channels for tape bytes in and loader results out.
// ----------------------------------------------------------------------------

// Tape byte channel.
interface tbl_in_if;
    logic             valid;
    logic             ready;
    tbl_pkg::in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// Result channel.
interface tbl_out_if;
    logic               valid;
    logic               ready;
    tbl_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ src/tape_block_loader.sv @@
// ----------------------------------------------------------------------------
// Tape block loader
// Checks the flag and XOR checksum of a tape data block and emits a memory
// write for each payload byte (unless verify-only is set) plus one status per block.
// ----------------------------------------------------------------------------
//
//  Channel      Direction  Handshake     Payload
//  tape_in      in         valid/ready   tape_byte, block_end
//  result_out   out        valid/ready   write_enable, write_address,
//                                        write_data, status_valid, status_code
//  cfg          in         cfg_we only   cfg_index, cfg_data
//
//  Each tape byte gives exactly one result, registered in the cycle after it is accepted.
//  A new byte is accepted every cycle while the result register is empty or
//  being emptied in the same cycle, so the throughput is one byte per cycle.
//  A stall on result_out holds the result register and drops tape_in.ready.
//  Reset clears the configuration, the block state and the result register.
//
module tape_block_loader (
    input  logic             clk,
    input  logic             rst_n,
    tbl_in_if.sink           tape_in,
    tbl_out_if.source        result_out,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data
);

    // Block phase codes.
    localparam logic [1:0] PH_FLAG = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_SUM  = 2'd2;
    localparam logic [1:0] PH_SKIP = 2'd3;

    logic [7:0]  required_flag_reg;
    logic [15:0] load_length_reg;
    logic [15:0] start_address_reg;
    logic        verify_only_reg;

    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic [15:0] byte_index_reg;
    logic [15:0] byte_index_next;
    logic [7:0]  running_xor_reg;
    logic [7:0]  running_xor_next;

    tbl_pkg::out_item_t result_reg;
    tbl_pkg::out_item_t result_next;
    logic               out_valid_reg;

    logic        in_accept;
    logic        out_accept;
    logic [15:0] index_inc;
    logic [7:0]  b;
    logic        last;

    // Handshakes: the result register frees up when it is empty or being read.
    assign tape_in.ready      = !out_valid_reg || result_out.ready;
    assign in_accept          = tape_in.valid && tape_in.ready;
    assign out_accept         = out_valid_reg && result_out.ready;
    assign result_out.valid   = out_valid_reg;
    assign result_out.payload = result_reg;

    assign b         = tape_in.payload.tape_byte;
    assign last      = tape_in.payload.block_end;
    assign index_inc = byte_index_reg + 16'd1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            required_flag_reg <= 8'd0;
            load_length_reg   <= 16'd0;
            start_address_reg <= 16'd0;
            verify_only_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tbl_pkg::REG_FLAG:   required_flag_reg <= cfg_data[7:0];
                tbl_pkg::REG_LENGTH: load_length_reg   <= cfg_data;
                tbl_pkg::REG_START:  start_address_reg <= cfg_data;
                tbl_pkg::REG_VERIFY: verify_only_reg   <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // Per-byte work: flag check, checksum accumulation and write generation.
    always_comb
    begin
        phase_next       = phase_reg;
        byte_index_next  = byte_index_reg;
        running_xor_next = running_xor_reg;
        result_next      = '0;

        case (phase_reg)
            PH_FLAG:
            begin
                if (b != required_flag_reg)
                begin
                    result_next.status_valid = 1'b1;
                    result_next.status_code  = tbl_pkg::ST_FLAG;
                    phase_next               = last ? PH_FLAG : PH_SKIP;
                end
                else if (last)
                begin
                    result_next.status_valid = 1'b1;
                    result_next.status_code  = tbl_pkg::ST_SHORT;
                    phase_next               = PH_FLAG;
                end
                else
                begin
                    running_xor_next = b;
                    byte_index_next  = 16'd0;
                    phase_next       = (load_length_reg == 16'd0) ? PH_SUM : PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (!verify_only_reg)
                begin
                    result_next.write_enable  = 1'b1;
                    result_next.write_address = start_address_reg + byte_index_reg;
                    result_next.write_data    = b;
                end
                running_xor_next = running_xor_reg ^ b;
                byte_index_next  = index_inc;
                if (last)
                begin
                    result_next.status_valid = 1'b1;
                    result_next.status_code  = tbl_pkg::ST_SHORT;
                    phase_next               = PH_FLAG;
                end
                else if (index_inc >= load_length_reg)
                begin
                    phase_next = PH_SUM;
                end
            end
            PH_SUM:
            begin
                result_next.status_valid = 1'b1;
                result_next.status_code  = (b == running_xor_reg) ? tbl_pkg::ST_OK
                                                                  : tbl_pkg::ST_SUM;
                phase_next               = last ? PH_FLAG : PH_SKIP;
            end
            default:
            begin
                // Bytes after the checksum or a bad flag are dropped silently.
                if (last)
                begin
                    phase_next = PH_FLAG;
                end
            end
        endcase
    end

    // Block state advances on every accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_FLAG;
            byte_index_reg  <= 16'd0;
            running_xor_reg <= 8'd0;
        end
        else if (in_accept)
        begin
            phase_reg       <= phase_next;
            byte_index_reg  <= byte_index_next;
            running_xor_reg <= running_xor_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_accept)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_reg <= '0;
        end
        else if (in_accept)
        begin
            result_reg <= result_next;
        end
    end

    // A stalled input can only be caused by a held result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !tape_in.ready |-> out_valid_reg)
        else $error("tape_in stalled with an empty result register");

    // Every accepted byte produces a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted byte produced no result");

    // A checksum byte always decides the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && phase_reg == PH_SUM) |=> result_reg.status_valid)
        else $error("checksum byte gave no status");

    // The end of a block always returns to the flag phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && last) |=> phase_reg == PH_FLAG)
        else $error("block end did not rearm the flag check");

    // Unused write fields stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_reg.write_enable) |->
            (result_reg.write_address == 16'd0 && result_reg.write_data == 8'd0))
        else $error("write fields set without a write");

    // A status is only ever given on a flag, payload or checksum byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && phase_reg == PH_SKIP) |=> !result_reg.status_valid)
        else $error("status given while skipping");

endmodule
